@@ sv/crc_byte_stuffed_frame_encoder_unit_macros.svh @@
// Assertion macros for the byte-stuffed CRC frame encoder.
// Used by the top level; expects clk and arst_n in scope.
`ifndef CRC_BYTE_STUFFED_FRAME_ENCODER_UNIT_MACROS_SVH
`define CRC_BYTE_STUFFED_FRAME_ENCODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CBSFE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbsfe assertion failed");
`define CBSFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbsfe assertion failed");
`else
`define CBSFE_ASSERT_NOW(label, ante, cons)
`define CBSFE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/cbsfe_pkg.sv @@
// Shared types, constants and functions of the byte-stuffed CRC frame encoder.
// No dependencies.
`default_nettype none
package cbsfe_pkg;

	localparam logic [7:0]  SOF_BYTE   = 8'h80;
	localparam logic [7:0]  EOF_BYTE   = 8'h0d;
	localparam logic [7:0]  ESC_BYTE   = 8'h1b;
	localparam logic [7:0]  ESC_FLIP   = 8'hff;
	localparam logic [7:0]  SPECIAL_40 = 8'h40;
	localparam logic [7:0]  SPECIAL_06 = 8'h06;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam int          QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       frame_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       run_last;
		logic       frame_done;
	} out_item_t;

	typedef struct packed {
		logic        start;
		logic        last;
		logic [7:0]  data;
		logic [15:0] crc;
	} job_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic needs_escape(input logic [7:0] v);
		return (v == SOF_BYTE) || (v == SPECIAL_40) || (v == EOF_BYTE) ||
			(v == SPECIAL_06) || (v == ESC_BYTE);
	endfunction

endpackage
`default_nettype wire

@@ sv/crc_byte_stuffed_frame_encoder_unit.sv @@
// Top level of the byte-stuffed CRC-16 frame encoder.
// Depends on cbsfe_pkg, cbsfe_front, cbsfe_queue, cbsfe_back and the macros header.
//
// Usage:
//   src channel (src_valid/src_ready/src_item) takes one unstuffed frame byte per
//   transfer with frame_last marking the final byte of a frame.
//   dst channel (dst_valid/dst_ready/dst_item) gives line bytes: start byte 0x80
//   ahead of a frame, stuffed data bytes, stuffed CRC high then low, stop byte 0x0d.
//   run_last marks the last line byte caused by one src transfer, frame_done the stop.
// An item's line bytes pass through a job queue slot and then the output register.
// Throughput: one line byte per cycle from the back end unless stalled or empty;
//   an item gives 1 to 8 line bytes (two for a typical opening or escaped byte).
//   The front end takes one item per cycle while the two-entry job queue has room.
// Reset: clears CRC, frame state, queue and output register; no frame is open.
// Stall: dst_ready low holds the output register; the back end stops, the queue
//   fills and then src_ready drops until space frees up.
`default_nettype none
`include "crc_byte_stuffed_frame_encoder_unit_macros.svh"
module crc_byte_stuffed_frame_encoder_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	output logic                     src_ready,
	input  wire cbsfe_pkg::in_item_t src_item,
	output logic                     dst_valid,
	input  wire logic                dst_ready,
	output cbsfe_pkg::out_item_t     dst_item
);

	logic            push;
	cbsfe_pkg::job_t push_job;
	logic            q_full;
	logic            pop;
	cbsfe_pkg::job_t head;
	logic            q_empty;
	logic            frame_open;
	logic            back_busy;

	cbsfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_ready  (src_ready),
		.src_item   (src_item),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job),
		.frame_open (frame_open)
	);

	cbsfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	cbsfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.busy      (back_busy),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_item  (dst_item)
	);

	`CBSFE_ASSERT_NOW(a_stop_closes_run, dst_valid && dst_item.frame_done,
		dst_item.line_byte == cbsfe_pkg::EOF_BYTE && dst_item.run_last)
	`CBSFE_ASSERT_NEXT(a_last_closes_frame,
		src_valid && src_ready && src_item.frame_last, !frame_open)
	`CBSFE_ASSERT_NOW(a_idle_when_empty, q_empty, !back_busy)

endmodule
`default_nettype wire

@@ sv/cbsfe_front.sv @@
// Front end: accepts frame bytes, tracks frame state and running CRC, queues jobs.
// Depends on cbsfe_pkg.
`default_nettype none
module cbsfe_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                src_valid,
	output logic                     src_ready,
	input  wire cbsfe_pkg::in_item_t src_item,
	input  wire logic                q_full,
	output logic                     push,
	output cbsfe_pkg::job_t          push_job,
	output logic                     frame_open
);

	logic [15:0] crc_q;
	logic        open_q;
	logic [15:0] crc_next;

	assign src_ready  = !q_full;
	assign push       = src_valid && !q_full;
	assign frame_open = open_q;

	always_comb begin
		crc_next       = cbsfe_pkg::crc_update(crc_q, src_item.payload_byte);
		push_job.start = !open_q;
		push_job.last  = src_item.frame_last;
		push_job.data  = src_item.payload_byte;
		push_job.crc   = crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			open_q <= 1'b0;
		end else if (push) begin
			if (src_item.frame_last) begin
				crc_q  <= '0;
				open_q <= 1'b0;
			end else begin
				crc_q  <= crc_next;
				open_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/cbsfe_queue.sv @@
// Short job queue between front end and back end.
// Depends on cbsfe_pkg.
`default_nettype none
module cbsfe_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire cbsfe_pkg::job_t push_job,
	output logic                 full,
	input  wire logic            pop,
	output cbsfe_pkg::job_t      head,
	output logic                 empty
);

	localparam int Depth = cbsfe_pkg::QUEUE_DEPTH;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);

	cbsfe_pkg::job_t slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CntW'(Depth));
	assign empty   = (cnt_q == '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/cbsfe_back.sv @@
// Back end: expands one queued job into optional start, stuffed data, and for a last job CRC and stop bytes.
// Depends on cbsfe_pkg.
`default_nettype none
module cbsfe_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cbsfe_pkg::job_t head,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 busy,
	output logic                 dst_valid,
	input  wire logic            dst_ready,
	output cbsfe_pkg::out_item_t dst_item
);

	typedef enum logic [2:0] {
		PH_START,
		PH_DATA,
		PH_CRC_HI,
		PH_CRC_LO,
		PH_STOP
	} phase_t;

	phase_t               phase_q;
	logic                 busy_q;
	logic                 esc_q;
	logic                 out_valid_q;
	cbsfe_pkg::out_item_t out_q;

	phase_t     ph;
	phase_t     nph;
	logic       load;
	logic       esc_cur;
	logic [7:0] v;
	logic [7:0] byte_out;
	logic       nesc;
	logic       jend;
	logic       done;

	assign load      = !empty && (!out_valid_q || dst_ready);
	assign pop       = load && jend;
	assign busy      = busy_q;
	assign dst_valid = out_valid_q;
	assign dst_item  = out_q;

	always_comb begin
		ph       = busy_q ? phase_q : (head.start ? PH_START : PH_DATA);
		esc_cur  = busy_q && esc_q;
		nph      = ph;
		nesc     = 1'b0;
		jend     = 1'b0;
		done     = 1'b0;
		byte_out = cbsfe_pkg::SOF_BYTE;
		unique case (ph)
			PH_DATA:   v = head.data;
			PH_CRC_HI: v = head.crc[15:8];
			PH_CRC_LO: v = head.crc[7:0];
			default:   v = '0;
		endcase
		unique case (ph)
			PH_START: begin
				byte_out = cbsfe_pkg::SOF_BYTE;
				nph      = PH_DATA;
			end
			PH_DATA, PH_CRC_HI, PH_CRC_LO: begin
				if (!esc_cur && cbsfe_pkg::needs_escape(v)) begin
					byte_out = cbsfe_pkg::ESC_BYTE;
					nesc     = 1'b1;
				end else begin
					byte_out = esc_cur ? (v ^ cbsfe_pkg::ESC_FLIP) : v;
					if (ph == PH_DATA) begin
						nph  = PH_CRC_HI;
						jend = !head.last;
					end else if (ph == PH_CRC_HI) begin
						nph = PH_CRC_LO;
					end else begin
						nph = PH_STOP;
					end
				end
			end
			PH_STOP: begin
				byte_out = cbsfe_pkg::EOF_BYTE;
				done     = 1'b1;
				jend     = 1'b1;
			end
			default: begin
				jend = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			busy_q      <= 1'b0;
			esc_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (load) begin
			out_valid_q      <= 1'b1;
			out_q.line_byte  <= byte_out;
			out_q.run_last   <= jend;
			out_q.frame_done <= done;
			busy_q           <= !jend;
			esc_q            <= nesc && !jend;
			phase_q          <= nph;
		end else if (dst_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire
